// File: design/sela_pkg.sv
// Shared types, constants and the stage quantizer of the speech envelope level stage.
package sela_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_STRIDE       = 2'd0;
    localparam logic [1:0] CFG_QUIET_FLOOR  = 2'd1;
    localparam logic [1:0] CFG_REFERENCE    = 2'd2;
    localparam logic [1:0] CFG_MIN_INTERVAL = 2'd3;

    // Reset values of the configuration registers
    localparam logic [7:0]  RST_STRIDE       = 8'd1;
    localparam logic [15:0] RST_QUIET_FLOOR  = 16'd0;
    localparam logic [15:0] RST_REFERENCE    = 16'd8192;
    localparam logic [15:0] RST_MIN_INTERVAL = 16'd0;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 40;
    localparam int LEVEL_W  = 7;
    localparam int STAGE_W  = 2;
    // Width of (mean - floor) * 100
    localparam int NUM_W    = 22;

    // Level scale and quantizer thresholds
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 7'd100;
    localparam logic [LEVEL_W-1:0] UP_0_TO_1   = 7'd14;
    localparam logic [LEVEL_W-1:0] DOWN_1_TO_0 = 7'd6;
    localparam logic [LEVEL_W-1:0] UP_1_TO_2   = 7'd38;
    localparam logic [LEVEL_W-1:0] DOWN_2_TO_1 = 7'd25;
    localparam logic [LEVEL_W-1:0] UP_2_TO_3   = 7'd72;
    localparam logic [LEVEL_W-1:0] DOWN_3_TO_2 = 7'd58;

    // Mouth stages
    localparam logic [STAGE_W-1:0] STAGE_QUIET = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_LOW   = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_MID   = 2'd2;
    localparam logic [STAGE_W-1:0] STAGE_LOUD  = 2'd3;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  stride;
        logic [15:0] quiet_floor;
        logic [15:0] reference;
        logic [15:0] min_interval;
    } cfg_t;

    // Status of a multi-cycle unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    // Four-stage quantizer with hysteresis.
    function automatic logic [STAGE_W-1:0] quantize(input logic [LEVEL_W-1:0] level,
                                                    input logic [STAGE_W-1:0] cur);
        logic [STAGE_W-1:0] nxt;
        nxt = cur;
        case (cur)
            STAGE_QUIET: nxt = (level >= UP_0_TO_1) ? STAGE_LOW : STAGE_QUIET;
            STAGE_LOW:
            begin
                if (level <= DOWN_1_TO_0)
                    nxt = STAGE_QUIET;
                else
                    nxt = (level >= UP_1_TO_2) ? STAGE_MID : STAGE_LOW;
            end
            STAGE_MID:
            begin
                if (level <= DOWN_2_TO_1)
                    nxt = STAGE_LOW;
                else
                    nxt = (level >= UP_2_TO_3) ? STAGE_LOUD : STAGE_MID;
            end
            default: nxt = (level <= DOWN_3_TO_2) ? STAGE_MID : STAGE_LOUD;
        endcase
        return nxt;
    endfunction

endpackage

// File: design/sela_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module sela_div #(
    parameter int DW = 28,
    parameter int VW = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DW-1:0]         dividend,
    input  logic [VW-1:0]         divisor,
    output sela_pkg::unit_status_t status,
    output logic [DW-1:0]         quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [VW:0]   shifted;
    logic          fits;
    logic [VW:0]   diff;
    logic [VW-1:0] rem_next;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DW-1]};
        fits     = (shifted >= {1'b0, dvs_reg});
        diff     = shifted - {1'b0, dvs_reg};
        rem_next = fits ? diff[VW-1:0] : shifted[VW-1:0];
    end

    // Step counter and handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(DW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Remainder and the dividend/quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// File: design/sela_level.sv
// Frame level computation: mean, floor removal and scaling to 0..100 on a shared divider.
module sela_level #(
    parameter int CNT_W = 13,
    parameter int SUM_W = 28
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [SUM_W-1:0]              sum,
    input  logic [CNT_W-1:0]              count,
    input  sela_pkg::cfg_t                cfg,
    output sela_pkg::unit_status_t        status,
    output logic [sela_pkg::LEVEL_W-1:0]  level
);

    localparam int DW = (SUM_W > sela_pkg::NUM_W) ? SUM_W : sela_pkg::NUM_W;
    localparam int VW = (CNT_W > sela_pkg::SAMPLE_W) ? CNT_W : sela_pkg::SAMPLE_W;

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_DIV1 = 2'd1;
    localparam logic [1:0] L_MUL  = 2'd2;
    localparam logic [1:0] L_DIV2 = 2'd3;

    logic [1:0]                     state_reg;
    logic                           done_reg;
    logic                           div_start_reg;
    logic [DW-1:0]                  dvd_reg;
    logic [VW-1:0]                  dvs_reg;
    logic [15:0]                    excess_reg;
    logic [sela_pkg::LEVEL_W-1:0]   level_reg;

    sela_pkg::unit_status_t         div_status;
    logic [DW-1:0]                  div_quo;

    logic                           zero_level;
    logic [15:0]                    mean;
    logic [sela_pkg::NUM_W-1:0]     scaled;
    logic [15:0]                    span;

    sela_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .status   (div_status),
        .quotient (div_quo)
    );

    // Operand preparation: degenerate settings, the mean and times-100 by shifts.
    always_comb
    begin
        zero_level = (cfg.stride == 8'd0) || (cfg.reference <= cfg.quiet_floor)
                     || (count == '0);
        mean       = div_quo[15:0];
        span       = cfg.reference - cfg.quiet_floor;
        scaled     = {excess_reg, 6'b0} + {1'b0, excess_reg, 5'b0}
                     + {4'b0, excess_reg, 2'b0};
    end

    // Sequencer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= L_IDLE;
            done_reg      <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= 1'b0;
            div_start_reg <= 1'b0;
            case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        if (zero_level)
                            done_reg <= 1'b1;
                        else
                        begin
                            div_start_reg <= 1'b1;
                            state_reg     <= L_DIV1;
                        end
                    end
                end
                L_DIV1:
                begin
                    if (div_status.done)
                    begin
                        if (mean <= cfg.quiet_floor)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= L_IDLE;
                        end
                        else
                            state_reg <= L_MUL;
                    end
                end
                L_MUL:
                begin
                    div_start_reg <= 1'b1;
                    state_reg     <= L_DIV2;
                end
                L_DIV2:
                begin
                    if (div_status.done)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                dvd_reg <= DW'(sum);
                dvs_reg <= VW'(count);
                if (start && zero_level)
                    level_reg <= '0;
            end
            L_DIV1:
            begin
                excess_reg <= mean - cfg.quiet_floor;
                if (div_status.done && (mean <= cfg.quiet_floor))
                    level_reg <= '0;
            end
            L_MUL:
            begin
                dvd_reg <= DW'(scaled);
                dvs_reg <= VW'(span);
            end
            L_DIV2:
            begin
                if (div_status.done)
                begin
                    if (div_quo > DW'(sela_pkg::LEVEL_MAX))
                        level_reg <= sela_pkg::LEVEL_MAX;
                    else
                        level_reg <= div_quo[sela_pkg::LEVEL_W-1:0];
                end
            end
            default: level_reg <= level_reg;
        endcase
    end

    assign status.busy = (state_reg != L_IDLE);
    assign status.done = done_reg;
    assign level       = level_reg;

endmodule

// File: design/speech_envelope_level_stage_unit.sv
// Top level of the speech envelope level stage: framing, accumulation, stage decision, output.
// A sample that does not end a frame is accepted without a stall; the next one may follow at once.
// A frame-end sample holds s_tready low while the bit-serial divider runs for the mean and then
// the scale (the scale is skipped when the mean is at or below the floor); shorter when
// the level is forced to zero, and longer while a previous result still waits for m_tready.
// rst_n clears all control state, the configuration to its defaults and the frame sums at once.
module speech_envelope_level_stage_unit #(
    parameter int MAX_FRAME = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // sample_value[15:0], time_ms[55:16], speaking_on[56]
    input  logic        s_tlast,   // frame_end
    input  logic [0:0]  s_tuser,   // action
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // new_stage[1:0], frame_level[8:2]
    // Configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int SUM_W = CNT_W + 15;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_START  = 2'd1;
    localparam logic [1:0] ST_CALC   = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0]                       state_reg;
    sela_pkg::cfg_t                   cfg_reg;
    logic                             speaking_reg;
    logic [sela_pkg::STAGE_W-1:0]     stage_reg;
    logic [sela_pkg::TIME_W-1:0]      last_switch_reg;
    logic [sela_pkg::TIME_W-1:0]      time_reg;
    logic [SUM_W-1:0]                 sum_reg;
    logic [CNT_W-1:0]                 count_reg;
    logic [7:0]                       phase_reg;
    logic                             m_tvalid_reg;
    logic [sela_pkg::STAGE_W-1:0]     out_stage_reg;
    logic [sela_pkg::LEVEL_W-1:0]     out_level_reg;

    sela_pkg::unit_status_t           lvl_status;
    logic [sela_pkg::LEVEL_W-1:0]     lvl_level;

    logic                             in_xfer;
    logic                             is_event;
    logic [15:0]                      raw;
    logic [15:0]                      mag;
    logic                             take;
    logic [8:0]                       phase_inc;
    logic [7:0]                       phase_next;
    logic [sela_pkg::STAGE_W-1:0]     stage_next;
    logic [sela_pkg::TIME_W-1:0]      elapsed;
    logic                             emit;
    logic                             out_free;

    sela_level #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_level (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == ST_START),
        .sum    (sum_reg),
        .count  (count_reg),
        .cfg    (cfg_reg),
        .status (lvl_status),
        .level  (lvl_level)
    );

    // Input decode, stride selection and the stage decision.
    always_comb
    begin
        in_xfer    = s_tvalid && s_tready;
        is_event   = s_tuser[0];
        raw        = s_tdata[15:0];
        mag        = raw[15] ? (~raw + 16'd1) : raw;
        take       = (phase_reg == 8'd0) && (count_reg < CNT_W'(MAX_FRAME));
        phase_inc  = {1'b0, phase_reg} + 9'd1;
        phase_next = (phase_inc >= {1'b0, cfg_reg.stride}) ? 8'd0 : phase_inc[7:0];
        stage_next = sela_pkg::quantize(lvl_level, stage_reg);
        elapsed    = time_reg - last_switch_reg;
        emit       = speaking_reg && (stage_next != stage_reg)
                     && (time_reg >= last_switch_reg)
                     && (elapsed >= sela_pkg::TIME_W'(cfg_reg.min_interval));
        out_free   = !m_tvalid_reg || m_tready;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stride       <= sela_pkg::RST_STRIDE;
            cfg_reg.quiet_floor  <= sela_pkg::RST_QUIET_FLOOR;
            cfg_reg.reference    <= sela_pkg::RST_REFERENCE;
            cfg_reg.min_interval <= sela_pkg::RST_MIN_INTERVAL;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                sela_pkg::CFG_STRIDE:       cfg_reg.stride       <= cfg_data[7:0];
                sela_pkg::CFG_QUIET_FLOOR:  cfg_reg.quiet_floor  <= cfg_data;
                sela_pkg::CFG_REFERENCE:    cfg_reg.reference    <= cfg_data;
                sela_pkg::CFG_MIN_INTERVAL: cfg_reg.min_interval <= cfg_data;
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Frame accumulation, speaking state and stage decision.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            speaking_reg    <= 1'b0;
            stage_reg       <= sela_pkg::STAGE_QUIET;
            last_switch_reg <= '0;
            sum_reg         <= '0;
            count_reg       <= '0;
            phase_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer && is_event)
                    begin
                        speaking_reg <= s_tdata[56];
                        if (s_tdata[56])
                        begin
                            stage_reg       <= sela_pkg::STAGE_MID;
                            last_switch_reg <= '0;
                        end
                    end
                    else if (in_xfer)
                    begin
                        if (take)
                        begin
                            sum_reg   <= sum_reg + SUM_W'(mag);
                            count_reg <= count_reg + 1'b1;
                        end
                        phase_reg <= phase_next;
                        if (s_tlast)
                            state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    // The level unit captures the sums at this edge.
                    sum_reg   <= '0;
                    count_reg <= '0;
                    phase_reg <= '0;
                    state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    if (lvl_status.done)
                        state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    if (!emit)
                        state_reg <= ST_IDLE;
                    else if (out_free)
                    begin
                        stage_reg       <= stage_next;
                        last_switch_reg <= time_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Output valid: set by an emitted change, cleared once the transfer is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if ((state_reg == ST_DECIDE) && emit && out_free)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer && !is_event && s_tlast)
            time_reg <= s_tdata[55:16];
        if ((state_reg == ST_DECIDE) && emit && out_free)
        begin
            out_stage_reg <= stage_next;
            out_level_reg <= lvl_level;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_level_reg, out_stage_reg};

    // The level unit reports completion only while the decision waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        lvl_status.done |-> (state_reg == ST_CALC))
        else $error("level unit finished outside the calculation phase");

    // An emitted level never exceeds full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (out_level_reg <= sela_pkg::LEVEL_MAX))
        else $error("frame level above full scale");

    // After an emitted change the current stage equals the reported stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DECIDE) && emit && out_free)
        |=> (m_tvalid_reg && (stage_reg == out_stage_reg)))
        else $error("stage register and emitted stage disagree");

    // The taken sample count is bounded by the frame limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_FRAME))
        else $error("taken sample count beyond frame limit");

endmodule
